@@ design/rfbe_pkg.sv @@
// ----------------------------------------------------------------------------
// rfbe_pkg
// shared types and constants of the rns fast basis extension unit
// ----------------------------------------------------------------------------
package rfbe_pkg;

    localparam int unsigned MOD_W = 61;

    typedef enum logic [1:0] {
        MODE_LOAD_Q    = 2'd0,
        MODE_LOAD_P    = 2'd1,
        MODE_LOAD_QHAT = 2'd2,
        MODE_RESIDUE   = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        REG_NUM_Q  = 2'd0,
        REG_NUM_P  = 2'd1,
        REG_RING   = 2'd2,
        REG_UNUSED = 2'd3
    } t_reg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_T1,
        ST_T2,
        ST_RED,
        ST_MUL,
        ST_ACC,
        ST_ADD,
        ST_OUT
    } t_state;

endpackage

@@ design/rfbe_ram.sv @@
// ----------------------------------------------------------------------------
// rfbe_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module rfbe_ram #(
    parameter int WIDTH = 61,
    parameter int DEPTH = 64
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/rfbe_modmul.sv @@
// ----------------------------------------------------------------------------
// rfbe_modmul
// bit-serial modular multiply, one multiplier bit per cycle
// result = (addend * mult) mod modulus, addend below modulus or equal to 1
// ----------------------------------------------------------------------------
module rfbe_modmul (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [rfbe_pkg::MOD_W-1:0]    i_addend,
    input  logic [rfbe_pkg::MOD_W-1:0]    i_mult,
    input  logic [rfbe_pkg::MOD_W-1:0]    i_mod,
    output logic                          o_done,
    output logic [rfbe_pkg::MOD_W-1:0]    o_res
);

    localparam int W  = rfbe_pkg::MOD_W;
    localparam int CW = $clog2(W);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [W-1:0]  r_r;
    logic [W-1:0]  r_a;
    logic [W-1:0]  r_b;
    logic [W-1:0]  r_m;
    logic          r_zero;

    logic [W:0]    w_mm;
    logic [W:0]    w_d;
    logic [W:0]    w_d1;
    logic [W:0]    w_s;
    logic [W:0]    w_s1;
    logic [W-1:0]  n_r;

    always_comb begin
        w_mm = {1'b0, r_m};
        w_d  = {r_r, 1'b0};
        w_d1 = (w_d >= w_mm) ? (w_d - w_mm) : w_d;
        w_s  = w_d1 + {1'b0, r_a};
        w_s1 = (w_s >= w_mm) ? (w_s - w_mm) : w_s;
        n_r  = r_b[r_cnt] ? w_s1[W-1:0] : w_d1[W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && (r_cnt == '0);
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == '0)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cnt  <= CW'(W - 1);
            r_r    <= '0;
            r_a    <= i_addend;
            r_b    <= i_mult;
            r_m    <= i_mod;
            r_zero <= (i_mod == '0);
        end else if (r_busy) begin
            r_r   <= n_r;
            r_cnt <= r_cnt - CW'(1);
        end
    end

    assign o_done = r_done;
    assign o_res  = r_zero ? '0 : r_r;

endmodule

@@ design/rns_fast_basis_extension_unit.sv @@
// ----------------------------------------------------------------------------
// rns_fast_basis_extension_unit
// approximate rns basis extension from the q moduli to the p moduli
// ----------------------------------------------------------------------------
// load beats only write the tables and keep the input ready; a residue beat runs one bit-serial multiplier:
// 2 ops for the q side, then 3 ops plus one add step per active p modulus,
// and the input is not ready again until all of them are done
// the last q residue then drives num_p result beats, one per cycle while i_m_axis_tready is high
// reset is synchronous active low; tables and accumulators are not cleared
// ----------------------------------------------------------------------------
module rns_fast_basis_extension_unit #(
    parameter int MAX_Q = 8,
    parameter int MAX_P = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [127:0] i_s_axis_tdata,  // q_index, p_index, word, aux_word
    input  logic [1:0]   i_s_axis_tuser,  // mode
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    output logic [63:0]  o_m_axis_tdata,  // target_index, residue
    output logic         o_m_axis_tlast,
    output logic [0:0]   o_m_axis_tuser,  // end_of_poly
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam int W  = rfbe_pkg::MOD_W;
    localparam int QW = (MAX_Q > 1) ? $clog2(MAX_Q) : 1;
    localparam int JW = (MAX_P > 1) ? $clog2(MAX_P) : 1;
    localparam int TD = MAX_Q * MAX_P;
    localparam int TW = (TD > 1) ? $clog2(TD) : 1;

    rfbe_pkg::t_state r_state, n_state;

    logic [3:0]   r_nq;
    logic [3:0]   r_np;
    logic [16:0]  r_rd;
    logic [16:0]  r_cnt;
    logic         r_eop;
    logic [2:0]   r_qi;
    logic [JW-1:0] r_j;
    logic [W-1:0] r_t;
    logic [W-1:0] r_prod;
    logic [W-1:0] r_q   [MAX_Q];
    logic [W-1:0] r_inv [MAX_Q];
    logic [W-1:0] r_p   [MAX_P];
    logic [W-1:0] r_acc [MAX_P];

    logic         w_in_acc;
    logic         w_cfg_wr;
    logic [2:0]   w_sq;
    logic [2:0]   w_sp;
    logic [W-1:0] w_sword;
    logic [W-1:0] w_saux;
    logic [7:0]   w_sq8;
    logic [7:0]   w_sp8;
    logic [7:0]   w_nq;
    logic [7:0]   w_np;
    logic [7:0]   w_qi8;
    logic [7:0]   w_j8;
    logic [QW-1:0] w_qidx;
    logic [W-1:0] w_pj;
    logic [W-1:0] w_gap;
    logic [W-1:0] w_sum;
    logic [16:0]  w_rd;
    logic         w_more_p;
    logic         w_last_q;
    logic         w_res_go;

    logic         u_start;
    logic         u_done;
    logic [W-1:0] u_addend;
    logic [W-1:0] u_mult;
    logic [W-1:0] u_mod;
    logic [W-1:0] u_res;

    logic         t_we;
    logic [TW-1:0] t_waddr;
    logic [TW-1:0] t_raddr;
    logic [W-1:0] t_rdata;

    assign w_sq    = i_s_axis_tdata[2:0];
    assign w_sp    = i_s_axis_tdata[5:3];
    assign w_sword = i_s_axis_tdata[66:6];
    assign w_saux  = i_s_axis_tdata[127:67];
    assign w_sq8   = {5'b0, w_sq};
    assign w_sp8   = {5'b0, w_sp};
    assign w_qi8   = {5'b0, r_qi};
    assign w_j8    = 8'(r_j);
    assign w_qidx  = w_qi8[QW-1:0];
    assign w_pj    = r_p[r_j];

    assign w_in_acc = i_s_axis_tvalid && o_s_axis_tready;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        if (r_nq == 4'd0) begin
            w_nq = 8'd1;
        end else if ({4'b0, r_nq} > 8'(MAX_Q)) begin
            w_nq = 8'(MAX_Q);
        end else begin
            w_nq = {4'b0, r_nq};
        end
        if (r_np == 4'd0) begin
            w_np = 8'd1;
        end else if ({4'b0, r_np} > 8'(MAX_P)) begin
            w_np = 8'(MAX_P);
        end else begin
            w_np = {4'b0, r_np};
        end
    end

    assign w_res_go = w_in_acc && (rfbe_pkg::t_mode'(i_s_axis_tuser) == rfbe_pkg::MODE_RESIDUE)
                      && (w_sq8 < w_nq);
    assign w_more_p = (w_j8 + 8'd1) < w_np;
    assign w_last_q = (w_qi8 + 8'd1) == w_nq;
    assign w_rd     = (r_rd == 17'd0) ? 17'd1 : r_rd;

    // modular add of the fresh product to the reduced accumulator
    always_comb begin
        w_gap = w_pj - u_res;
        if (w_pj == '0) begin
            w_sum = '0;
        end else if (r_prod >= w_gap) begin
            w_sum = r_prod - w_gap;
        end else begin
            w_sum = u_res + r_prod;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rfbe_pkg::ST_IDLE: if (w_res_go) n_state = rfbe_pkg::ST_T1;
            rfbe_pkg::ST_T1:   if (u_done) n_state = rfbe_pkg::ST_T2;
            rfbe_pkg::ST_T2:   if (u_done) n_state = rfbe_pkg::ST_RED;
            rfbe_pkg::ST_RED:  if (u_done) n_state = rfbe_pkg::ST_MUL;
            rfbe_pkg::ST_MUL:  if (u_done) n_state = rfbe_pkg::ST_ACC;
            rfbe_pkg::ST_ACC:  if (u_done) n_state = rfbe_pkg::ST_ADD;
            rfbe_pkg::ST_ADD: begin
                if (w_more_p) begin
                    n_state = rfbe_pkg::ST_RED;
                end else if (w_last_q) begin
                    n_state = rfbe_pkg::ST_OUT;
                end else begin
                    n_state = rfbe_pkg::ST_IDLE;
                end
            end
            rfbe_pkg::ST_OUT: begin
                if (i_m_axis_tready && !w_more_p) n_state = rfbe_pkg::ST_IDLE;
            end
            default: n_state = rfbe_pkg::ST_IDLE;
        endcase
    end

    // outputs and multiplier operands
    always_comb begin
        o_s_axis_tready = (r_state == rfbe_pkg::ST_IDLE);
        o_m_axis_tvalid = (r_state == rfbe_pkg::ST_OUT);
        o_m_axis_tdata  = {r_acc[r_j], w_j8[2:0]};
        o_m_axis_tlast  = !w_more_p;
        o_m_axis_tuser  = !w_more_p && r_eop;
        u_start  = (n_state != r_state) && (n_state != rfbe_pkg::ST_IDLE)
                   && (n_state != rfbe_pkg::ST_ADD) && (n_state != rfbe_pkg::ST_OUT);
        u_addend = W'(1);
        u_mult   = r_t;
        u_mod    = w_pj;
        unique case (n_state)
            rfbe_pkg::ST_T1: begin
                u_mult = w_sword;
                u_mod  = r_q[w_sq8[QW-1:0]];
            end
            rfbe_pkg::ST_T2: begin
                u_addend = u_res;
                u_mult   = r_inv[w_qidx];
                u_mod    = r_q[w_qidx];
            end
            rfbe_pkg::ST_RED: begin
                u_mult = (r_state == rfbe_pkg::ST_T2) ? u_res : r_t;
                u_mod  = (r_state == rfbe_pkg::ST_T2) ? r_p[0] : r_p[r_j + JW'(1)];
            end
            rfbe_pkg::ST_MUL: begin
                u_addend = u_res;
                u_mult   = t_rdata;
            end
            rfbe_pkg::ST_ACC: begin
                u_mult = r_acc[r_j];
            end
            default: begin
                u_mult = r_t;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rfbe_pkg::ST_IDLE;
            r_nq    <= 4'd1;
            r_np    <= 4'd1;
            r_rd    <= 17'd4096;
            r_cnt   <= '0;
            r_eop   <= 1'b0;
            r_j     <= '0;
        end else begin
            r_state <= n_state;
            if (w_cfg_wr) begin
                unique case (rfbe_pkg::t_reg_idx'(paddr[3:2]))
                    rfbe_pkg::REG_NUM_Q:  r_nq <= pwdata[3:0];
                    rfbe_pkg::REG_NUM_P:  r_np <= pwdata[3:0];
                    rfbe_pkg::REG_RING:   r_rd <= pwdata[16:0];
                    rfbe_pkg::REG_UNUSED: r_rd <= r_rd;
                endcase
            end
            if ((r_state == rfbe_pkg::ST_T2) && u_done) begin
                r_j <= '0;
            end else if (r_state == rfbe_pkg::ST_ADD) begin
                if (w_more_p) begin
                    r_j <= r_j + JW'(1);
                end else begin
                    r_j <= '0;
                    if (w_last_q) begin
                        r_eop <= (r_cnt >= (w_rd - 17'd1));
                        r_cnt <= (r_cnt >= (w_rd - 17'd1)) ? 17'd0 : r_cnt + 17'd1;
                    end
                end
            end else if ((r_state == rfbe_pkg::ST_OUT) && i_m_axis_tready) begin
                r_j <= w_more_p ? r_j + JW'(1) : '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            unique case (rfbe_pkg::t_mode'(i_s_axis_tuser))
                rfbe_pkg::MODE_LOAD_Q: begin
                    if (w_sq8 < 8'(MAX_Q)) begin
                        r_q[w_sq8[QW-1:0]]   <= w_sword;
                        r_inv[w_sq8[QW-1:0]] <= w_saux;
                    end
                end
                rfbe_pkg::MODE_LOAD_P: begin
                    if (w_sp8 < 8'(MAX_P)) r_p[w_sp8[JW-1:0]] <= w_sword;
                end
                rfbe_pkg::MODE_LOAD_QHAT: ;
                rfbe_pkg::MODE_RESIDUE: begin
                    if (w_sq8 < w_nq) begin
                        r_qi <= w_sq;
                        if (w_sq == 3'd0) begin
                            for (int k = 0; k < MAX_P; k++) r_acc[k] <= '0;
                        end
                    end
                end
            endcase
        end
        if ((r_state == rfbe_pkg::ST_T2) && u_done) r_t <= u_res;
        if ((r_state == rfbe_pkg::ST_MUL) && u_done) r_prod <= u_res;
        if (r_state == rfbe_pkg::ST_ADD) r_acc[r_j] <= w_sum;
    end

    assign t_we    = w_in_acc && (rfbe_pkg::t_mode'(i_s_axis_tuser) == rfbe_pkg::MODE_LOAD_QHAT)
                     && (w_sq8 < 8'(MAX_Q)) && (w_sp8 < 8'(MAX_P));
    assign t_waddr = TW'(32'(w_sq8) * MAX_P + 32'(w_sp8));
    assign t_raddr = TW'(32'(w_qi8) * MAX_P + 32'(w_j8));

    rfbe_ram #(
        .WIDTH(W),
        .DEPTH(TD)
    ) u_qhat_ram (
        .i_clk  (i_clk),
        .i_we   (t_we),
        .i_waddr(t_waddr),
        .i_wdata(w_sword),
        .i_raddr(t_raddr),
        .o_rdata(t_rdata)
    );

    rfbe_modmul u_modmul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (u_start),
        .i_addend(u_addend),
        .i_mult  (u_mult),
        .i_mod   (u_mod),
        .o_done  (u_done),
        .o_res   (u_res)
    );

    assign pready = 1'b1;

    always_comb begin
        unique case (rfbe_pkg::t_reg_idx'(paddr[3:2]))
            rfbe_pkg::REG_NUM_Q:  prdata = {28'b0, r_nq};
            rfbe_pkg::REG_NUM_P:  prdata = {28'b0, r_np};
            rfbe_pkg::REG_RING:   prdata = {15'b0, r_rd};
            rfbe_pkg::REG_UNUSED: prdata = '0;
        endcase
    end

    a_done_in_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        u_done |-> (r_state == rfbe_pkg::ST_T1 || r_state == rfbe_pkg::ST_T2 ||
                    r_state == rfbe_pkg::ST_RED || r_state == rfbe_pkg::ST_MUL ||
                    r_state == rfbe_pkg::ST_ACC))
        else $error("multiplier done outside an operation state");

    a_busy_after_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_s_axis_tready) |-> $past(i_s_axis_tvalid))
        else $error("busy without an accepted beat");

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_s_axis_tready && o_m_axis_tvalid))
        else $error("input taken while results pending");

    a_eop_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser[0]) |-> o_m_axis_tlast)
        else $error("end of polynomial away from last beat");

endmodule

@@ dv/rfbe_checker.sv @@
// ----------------------------------------------------------------------------
// rfbe_checker
// watches the input, output and register ports of the basis extension unit,
// predicts the target residues of every coefficient and compares them beat
// by beat, in order, with what the unit sends
// ----------------------------------------------------------------------------
module rfbe_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    input  logic         i_s_axis_tready,
    input  logic [127:0] i_s_axis_tdata,
    input  logic [1:0]   i_s_axis_tuser,
    input  logic         i_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    input  logic [63:0]  i_m_axis_tdata,
    input  logic         i_m_axis_tlast,
    input  logic [0:0]   i_m_axis_tuser,
    input  logic         i_psel,
    input  logic         i_penable,
    input  logic         i_pwrite,
    input  logic [3:0]   i_paddr,
    input  logic [31:0]  i_pwdata,
    input  logic         i_pready,
    output int           o_pending,
    output int           o_fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NQ = 8;
    localparam int NP = 8;
    localparam int MW = rfbe_pkg::MOD_W;

    typedef struct packed {
        logic [2:0]    target;
        logic [MW-1:0] residue;
        logic          last;
        logic          eop;
    } t_target_res;

    logic [MW-1:0] q_mod  [NQ];
    logic [MW-1:0] inv_qh [NQ];
    logic [MW-1:0] p_mod  [NP];
    logic [MW-1:0] qh_p   [NQ][NP];
    logic [MW-1:0] acc    [NP];
    logic [16:0]   coeff_cnt;
    logic [3:0]    num_q;
    logic [3:0]    num_p;
    logic [16:0]   ring;
    t_target_res   expected_res[$];

    initial begin
        o_pending    = 0;
        o_fail_count = 0;
    end

    function automatic logic [MW-1:0] mod_red(logic [63:0] a, logic [MW-1:0] m);
        return (m == 0) ? '0 : MW'(a % m);
    endfunction

    function automatic logic [MW-1:0] mod_mul(logic [MW-1:0] a, logic [MW-1:0] b,
                                              logic [MW-1:0] m);
        logic [127:0] prod;
        if (m == 0) return '0;
        prod = 128'(a % m) * 128'(b % m);
        return MW'(prod % 128'(m));
    endfunction

    function automatic int clamp_cnt(logic [3:0] v, int hi);
        if (v == 0) return 1;
        return (v > hi) ? hi : int'(v);
    endfunction

    task automatic report_mismatch(string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        o_fail_count++;
    endtask

    task automatic extend_residue(logic [2:0] qi, logic [MW-1:0] x);
        int nq;
        int np;
        int rd;
        logic [MW-1:0] t;
        logic [MW-1:0] r;
        logic eop;
        t_target_res res;
        nq = clamp_cnt(num_q, NQ);
        np = clamp_cnt(num_p, NP);
        if (qi >= nq) return;
        if (qi == 0) foreach (acc[j]) acc[j] = '0;
        t = mod_mul(x, inv_qh[qi], q_mod[qi]);
        for (int j = 0; j < np; j++) begin
            r = mod_red(64'(t), p_mod[j]);
            r = mod_mul(r, qh_p[qi][j], p_mod[j]);
            acc[j] = (p_mod[j] == 0) ? '0 :
                     mod_red(64'(mod_red(64'(acc[j]), p_mod[j])) + 64'(r), p_mod[j]);
        end
        if (qi != nq - 1) return;
        rd  = (ring == 0) ? 1 : int'(ring);
        eop = (int'(coeff_cnt) >= rd - 1);
        coeff_cnt = eop ? '0 : coeff_cnt + 1'b1;
        for (int j = 0; j < np; j++) begin
            res.target  = 3'(j);
            res.residue = acc[j];
            res.last    = (j == np - 1);
            res.eop     = (j == np - 1) && eop;
            expected_res.push_back(res);
        end
    endtask

    always @(posedge i_clk) begin
        t_target_res     want;
        rfbe_pkg::t_mode mode;
        logic [2:0]      qi;
        logic [2:0]      pi;
        if (!i_rst_n) begin
            coeff_cnt = '0;
            num_q     = 4'd1;
            num_p     = 4'd1;
            ring      = 17'd4096;
            expected_res.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (rfbe_pkg::t_reg_idx'(i_paddr[3:2]))
                    rfbe_pkg::REG_NUM_Q: num_q = i_pwdata[3:0];
                    rfbe_pkg::REG_NUM_P: num_p = i_pwdata[3:0];
                    rfbe_pkg::REG_RING:  ring  = i_pwdata[16:0];
                    default: ;
                endcase
            end
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                if (expected_res.size() == 0) begin
                    report_mismatch($sformatf("unexpected beat tdata=%h", i_m_axis_tdata));
                end else begin
                    want = expected_res.pop_front();
                    if (i_m_axis_tdata[2:0] !== want.target)
                        report_mismatch($sformatf("target %0d, want %0d",
                                                  i_m_axis_tdata[2:0], want.target));
                    if (i_m_axis_tdata[63:3] !== want.residue)
                        report_mismatch($sformatf("residue %h, want %h (target %0d)",
                                                  i_m_axis_tdata[63:3], want.residue,
                                                  want.target));
                    if (i_m_axis_tlast !== want.last)
                        report_mismatch($sformatf("tlast %b, want %b",
                                                  i_m_axis_tlast, want.last));
                    if (i_m_axis_tuser[0] !== want.eop)
                        report_mismatch($sformatf("end of poly %b, want %b",
                                                  i_m_axis_tuser[0], want.eop));
                end
            end
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                mode = rfbe_pkg::t_mode'(i_s_axis_tuser);
                qi   = i_s_axis_tdata[2:0];
                pi   = i_s_axis_tdata[5:3];
                case (mode)
                    rfbe_pkg::MODE_LOAD_Q: begin
                        q_mod[qi]  = i_s_axis_tdata[66:6];
                        inv_qh[qi] = i_s_axis_tdata[127:67];
                    end
                    rfbe_pkg::MODE_LOAD_P:    p_mod[pi]    = i_s_axis_tdata[66:6];
                    rfbe_pkg::MODE_LOAD_QHAT: qh_p[qi][pi] = i_s_axis_tdata[66:6];
                    default:                  extend_residue(qi, i_s_axis_tdata[66:6]);
                endcase
            end
        end
        o_pending = expected_res.size();
    end

endmodule

@@ dv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// stimulus for the rns fast basis extension unit: loads the modulus tables,
// runs directed corner cases and random coefficient sequences over many
// register settings with random idling and back pressure; the checker
// predicts and compares the target residues
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 30000;
    localparam int SETTLE     = 2000;
    localparam int ITEM_GOAL  = 450;
    localparam int MW         = rfbe_pkg::MOD_W;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_valid = 1'b0;
    logic         s_ready;
    logic [127:0] s_data = '0;   // q_index, p_index, word, aux_word
    logic [1:0]   s_user = '0;   // mode
    logic         m_valid;
    logic         m_ready = 1'b0;
    logic [63:0]  m_data;        // target_index, residue
    logic         m_last;
    logic [0:0]   m_user;        // end_of_poly
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [3:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;
    int           pending;
    int           fail_count;
    int           idle_cycles = 0;
    int           items_sent = 0;
    bit           tx_gaps = 1'b1;
    bit           rx_gaps = 1'b1;
    bit           rx_hold = 1'b0;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    rns_fast_basis_extension_unit DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tlast  (m_last),
        .o_m_axis_tuser  (m_user),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    rfbe_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .i_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .i_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .i_m_axis_tdata  (m_data),
        .i_m_axis_tlast  (m_last),
        .i_m_axis_tuser  (m_user),
        .i_psel          (psel),
        .i_penable       (penable),
        .i_pwrite        (pwrite),
        .i_paddr         (paddr),
        .i_pwdata        (pwdata),
        .i_pready        (pready),
        .o_pending       (pending),
        .o_fail_count    (fail_count)
    );

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_valid && s_ready) || (m_valid && m_ready) || (psel && penable))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // receiver with random stalls and one long hold-off on request
    initial begin
        forever begin
            @(posedge i_clk);
            if (rx_hold) begin
                m_ready <= 1'b0;
                repeat (5000) @(posedge i_clk);
                rx_hold = 1'b0;
            end else begin
                m_ready <= rx_gaps ? ($urandom_range(99) >= 26) : 1'b1;
            end
        end
    end

    function automatic logic [MW-1:0] rand_word();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            2:       return MW'($urandom_range(1000));
            default: return MW'({$urandom, $urandom});
        endcase
    endfunction

    function automatic logic [MW-1:0] rand_modulus();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2:       return MW'($urandom_range(2, 5000));
            default: return MW'({$urandom, $urandom}) | 1'b1;
        endcase
    endfunction

    task automatic send_beat(rfbe_pkg::t_mode mode, logic [2:0] qi, logic [2:0] pi,
                             logic [MW-1:0] word, logic [MW-1:0] aux);
        if (tx_gaps && $urandom_range(99) < 26) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_user  <= mode;
        s_data  <= {aux, word, pi, qi};
        do @(posedge i_clk); while (!s_ready);
        items_sent++;
    endtask

    task automatic send_residue(logic [2:0] qi, logic [MW-1:0] x);
        send_beat(rfbe_pkg::MODE_RESIDUE, qi, 3'($urandom), x, MW'({$urandom, $urandom}));
    endtask

    // sender pauses until every result is back, then lets the unit settle
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic reg_write(rfbe_pkg::t_reg_idx idx, logic [31:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_regs(logic [3:0] nq, logic [3:0] np, logic [16:0] rd);
        reg_write(rfbe_pkg::REG_NUM_Q, 32'(nq));
        reg_write(rfbe_pkg::REG_NUM_P, 32'(np));
        reg_write(rfbe_pkg::REG_RING, 32'(rd));
    endtask

    task automatic load_tables();
        for (int i = 0; i < 8; i++)
            send_beat(rfbe_pkg::MODE_LOAD_Q, 3'(i), 3'($urandom),
                      MW'({$urandom, $urandom}) | 1'b1, rand_word());
        for (int j = 0; j < 8; j++)
            send_beat(rfbe_pkg::MODE_LOAD_P, 3'($urandom), 3'(j),
                      MW'({$urandom, $urandom}) | 1'b1, rand_word());
        for (int i = 0; i < 8; i++)
            for (int j = 0; j < 8; j++)
                send_beat(rfbe_pkg::MODE_LOAD_QHAT, 3'(i), 3'(j), rand_word(), rand_word());
    endtask

    task automatic send_coeff(int nq);
        for (int i = 0; i < nq; i++) send_residue(3'(i), rand_word());
    endtask

    function automatic int eff_count(logic [3:0] v);
        if (v == 0) return 1;
        return (v > 8) ? 8 : int'(v);
    endfunction

    initial begin
        logic [3:0]  nq;
        logic [3:0]  np;
        logic [16:0] rd;
        int          phase;
        int          ncoef;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: tables, field extremes, zero moduli, inactive index, counts
        load_tables();
        send_residue(3'd0, '0);
        send_residue(3'd0, '1);
        drain();
        set_regs(4'd2, 4'd2, 17'd2);
        send_residue(3'd0, '1);
        send_residue(3'd1, '1);
        send_residue(3'd2, '1);
        send_residue(3'd7, '0);
        send_residue(3'd0, '0);
        send_residue(3'd1, MW'(12345));
        send_beat(rfbe_pkg::MODE_LOAD_Q, 3'd1, 3'd0, '0, '1);
        send_beat(rfbe_pkg::MODE_LOAD_P, 3'd0, 3'd1, '0, '0);
        send_coeff(2);
        send_beat(rfbe_pkg::MODE_LOAD_Q, 3'd1, 3'd0, MW'(97), MW'(5));
        send_beat(rfbe_pkg::MODE_LOAD_P, 3'd0, 3'd1, '1, '0);
        send_coeff(2);
        drain();
        set_regs(4'd0, 4'd0, 17'd0);
        send_coeff(1);
        send_coeff(1);
        drain();
        set_regs(4'd15, 4'd15, 17'd65536);
        send_coeff(8);
        drain();

        // random phases
        phase = 0;
        while (items_sent < ITEM_GOAL) begin
            case ($urandom_range(9))
                0:       nq = 4'($urandom_range(9, 15));
                1:       nq = 4'd0;
                2:       nq = 4'd8;
                default: nq = 4'($urandom_range(1, 4));
            endcase
            case ($urandom_range(9))
                0:       np = 4'($urandom_range(9, 15));
                1:       np = 4'd0;
                2:       np = 4'd8;
                default: np = 4'($urandom_range(1, 3));
            endcase
            case ($urandom_range(5))
                0:       rd = 17'd0;
                1:       rd = 17'd65536;
                2:       rd = 17'($urandom);
                default: rd = 17'($urandom_range(1, 5));
            endcase
            set_regs(nq, np, rd);
            tx_gaps = (phase != 2);
            rx_gaps = (phase != 2);
            if (phase == 1) begin
                set_regs(4'd1, 4'd1, 17'd3);
                nq = 4'd1;
                rx_hold = 1'b1;
            end
            repeat ($urandom_range(0, 4)) begin
                case ($urandom_range(2))
                    0: send_beat(rfbe_pkg::MODE_LOAD_Q, 3'($urandom), 3'($urandom),
                                 rand_modulus(), rand_word());
                    1: send_beat(rfbe_pkg::MODE_LOAD_P, 3'($urandom), 3'($urandom),
                                 rand_modulus(), rand_word());
                    default: send_beat(rfbe_pkg::MODE_LOAD_QHAT, 3'($urandom), 3'($urandom),
                                       rand_word(), rand_word());
                endcase
            end
            ncoef = (phase == 1) ? 12 : $urandom_range(2, 6);
            repeat (ncoef) begin
                case ($urandom_range(9))
                    0: send_residue(3'($urandom), rand_word());
                    1: send_coeff($urandom_range(1, eff_count(nq)));
                    2: begin
                        send_beat(rfbe_pkg::MODE_LOAD_QHAT, 3'($urandom), 3'($urandom),
                                  rand_word(), rand_word());
                        send_coeff(eff_count(nq));
                    end
                    default: send_coeff(eff_count(nq));
                endcase
            end
            drain();
            phase++;
        end

        tx_gaps = 1'b1;
        drain();
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

@@ files.f @@
design/rfbe_pkg.sv
design/rfbe_ram.sv
design/rfbe_modmul.sv
design/rns_fast_basis_extension_unit.sv
dv/rfbe_checker.sv
dv/tb_top.sv
